// ----- hdl/lfoc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfoc_pkg
// Register map, reset values and fixed-point constants of the chorus block.
// ----------------------------------------------------------------------------
package lfoc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int BASE_W    = 20;
    localparam int DEPTH_W   = 20;
    localparam int PERIOD_W  = 24;
    localparam int STEP_W    = 32;
    localparam int DRYWET_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_DEPTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_PERIOD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY_WET    = 3'd4;

    localparam logic [BASE_W-1:0]   RST_BASE_DELAY = 20'd282240;
    localparam logic [DEPTH_W-1:0]  RST_MOD_DEPTH  = 20'd11290;
    localparam logic [PERIOD_W-1:0] RST_LFO_PERIOD = 24'd55125;
    localparam logic [STEP_W-1:0]   RST_PHASE_STEP = 32'd77914;
    localparam logic [DRYWET_W-1:0] RST_DRY_WET    = 17'd65536;

    // quarter-wave sine polynomial, Q15
    localparam logic [16:0] SIN_A = 17'd51472;
    localparam logic [16:0] SIN_B = 17'd21024;
    localparam logic [16:0] SIN_C = 17'd2320;

    localparam logic [16:0] UNITY_GAIN = 17'd65536;
    localparam logic [15:0] WET_GAIN   = 16'd39322;

endpackage : lfoc_pkg
`default_nettype wire

// ----- hdl/lfoc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfoc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : lfoc_ram
`default_nettype wire

// ----- hdl/lfoc_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfoc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lfoc_mul #(
    parameter int A_W = 24,
    parameter int B_W = 18
) (
    input  wire logic                        aclk,
    input  wire logic signed [A_W-1:0]       op_a,
    input  wire logic signed [B_W-1:0]       op_b,
    output logic      signed [A_W+B_W-1:0]   product_reg
);

    always_ff @(posedge aclk) begin
        product_reg <= op_a * op_b;
    end

endmodule : lfoc_mul
`default_nettype wire

// ----- hdl/lfo_modulated_chorus.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_modulated_chorus
// Mono chorus: sine-LFO modulated delay line with interpolated taps and mix.
// ----------------------------------------------------------------------------
// After reset the delay memory is swept to zero, one entry per clock, so the
// block holds s_tready low until all DELAY_WORDS entries (4096 by default)
// are cleared; register writes are taken during the sweep. Each input word
// then runs through the states ST_X2 to ST_OUT, where its result is loaded
// into the output register: the sine polynomial, the delay product, the two
// tap weights and the mix gains are ten products run one after another
// through a single shared multiplier, with the two taps read from the one
// read port of the delay RAM. No new word is taken while one is in progress;
// the next is taken once the result is in the output register, also while it
// still waits on m_tready; a stalled output holds the block while it waits.
// SINE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
module lfo_modulated_chorus
    import lfoc_pkg::*;
#(
    parameter int DELAY_WORDS  = 4096,
    parameter int SAMPLE_BITS  = 16,
    parameter int SINE_ENTRIES = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // sample_in

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // sample_out

    input  wire logic                              cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0]             cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW      = $clog2(DELAY_WORDS);
    localparam int SW      = $clog2(SINE_ENTRIES);
    localparam int MUL_A_W = (SAMPLE_BITS + 8 > 21) ? SAMPLE_BITS + 8 : 21;
    localparam int MUL_B_W = 18;
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = SAMPLE_BITS + 28;
    localparam int WET_W   = SAMPLE_BITS + 8;
    localparam int D_W     = 37;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = {{(ACC_W-24){1'b0}}, 1'b1, 23'b0};
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_X2, ST_RC, ST_RB, ST_Y, ST_D,
        ST_GW, ST_DRY, ST_TA, ST_TB, ST_MIX, ST_OUT
    } state_t;

    // control
    state_t                 state_reg;
    logic                   m_tvalid_reg;
    logic [TDATA_W-1:0]     m_tdata_reg;
    logic [AW-1:0]          clr_ptr_reg;
    logic [AW-1:0]          wp_reg;
    logic [PERIOD_W-1:0]    lfo_count_reg;
    logic [STEP_W-1:0]      lfo_phase_reg;
    logic [BASE_W-1:0]      base_delay_reg;
    logic [DEPTH_W-1:0]     mod_depth_reg;
    logic [PERIOD_W-1:0]    lfo_period_reg;
    logic [STEP_W-1:0]      phase_step_reg;
    logic [DRYWET_W-1:0]    dry_wet_reg;

    // datapath
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [16:0]                   xq_reg;
    logic                          neg_reg;
    logic [16:0]                   x2_reg;
    logic [AW-1:0]                 di_reg;
    logic [8:0]                    df_reg;
    logic [AW-1:0]                 ia_reg;
    logic [15:0]                   gwet_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [WET_W-1:0]       wet_reg;

    logic                          s_accept;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [P_W-1:0]         mul_p;
    logic [16:0]                   p_hi15;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;

    logic [15:0]                   t_cur;
    logic [14:0]                   u_cur;
    logic [15:0]                   fold_cur;
    logic [16:0]                   x_cur;
    logic [16:0]                   r_b_cur;
    logic [16:0]                   r_a_cur;
    logic [14:0]                   ycap_cur;
    logic signed [15:0]            ymag_cur;
    logic signed [15:0]            sine_cur;
    logic [DEPTH_W-1:0]            depth_cap;
    logic [DRYWET_W-1:0]           dw_cap;
    logic [16:0]                   gdry;
    logic signed [D_W-1:0]         d_cur;
    logic [21:0]                   dq_cur;
    logic [13:0]                   di_raw;
    logic [AW-1:0]                 ia_cur;
    logic [AW-1:0]                 ib_cur;
    logic [8:0]                    w_a;
    logic signed [WET_W-1:0]       wet_sum;
    logic signed [ACC_W-1:0]       y_full;
    logic [SAMPLE_BITS-1:0]        y_sat;
    logic [PERIOD_W-1:0]           period_eff;
    logic [PERIOD_W-1:0]           cnt_inc;
    logic                          out_free;
    logic                          out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // LFO sine source
    assign t_cur    = 16'(lfo_phase_reg[31 -: SW]) << (16 - SW);
    assign u_cur    = t_cur[14:0];
    assign fold_cur = 16'h8000 - {1'b0, u_cur};
    assign x_cur    = (u_cur < 15'd16384) ? {1'b0, u_cur, 1'b0} : {fold_cur, 1'b0};
    assign p_hi15   = mul_p[15 +: 17];
    assign r_b_cur  = SIN_B - p_hi15;
    assign r_a_cur  = SIN_A - p_hi15;
    assign ycap_cur = (p_hi15 > 17'd32767) ? 15'h7fff : p_hi15[14:0];
    assign ymag_cur = $signed({1'b0, ycap_cur});
    assign sine_cur = neg_reg ? -ymag_cur : ymag_cur;

    // gains and delay
    assign depth_cap = (mod_depth_reg < base_delay_reg) ? mod_depth_reg : base_delay_reg;
    assign dw_cap    = (dry_wet_reg > UNITY_GAIN) ? UNITY_GAIN : dry_wet_reg;
    assign gdry      = UNITY_GAIN - 17'(dw_cap >> 1);
    assign d_cur     = $signed({2'b00, base_delay_reg, 15'b0}) + D_W'(mul_p);
    assign dq_cur    = d_cur[D_W-1:15];
    assign di_raw    = dq_cur[21:8];
    assign ia_cur    = (wp_reg >= di_reg) ? AW'(wp_reg - di_reg)
                     : AW'((AW+1)'(DELAY_WORDS) + {1'b0, wp_reg} - {1'b0, di_reg});
    assign ib_cur    = (ia_reg == '0) ? AW'(DELAY_WORDS - 1) : AW'(ia_reg - AW'(1));
    assign w_a       = 9'd256 - df_reg;
    assign wet_sum   = wet_reg + WET_W'(mul_p);

    // output saturation
    assign y_full = acc_reg >>> 24;
    assign y_sat  = (y_full > Y_MAX) ? Y_MAX[SAMPLE_BITS-1:0]
                  : (y_full < Y_MIN) ? Y_MIN[SAMPLE_BITS-1:0]
                  : y_full[SAMPLE_BITS-1:0];

    assign period_eff = (lfo_period_reg == '0) ? PERIOD_W'(1) : lfo_period_reg;
    assign cnt_inc    = lfo_count_reg + PERIOD_W'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE: begin
                mul_a = MUL_A_W'($signed({1'b0, x_cur}));
                mul_b = MUL_B_W'($signed({1'b0, x_cur}));
            end
            ST_X2: begin
                mul_a = MUL_A_W'($signed({1'b0, p_hi15}));
                mul_b = MUL_B_W'($signed({1'b0, SIN_C}));
            end
            ST_RC: begin
                mul_a = MUL_A_W'($signed({1'b0, r_b_cur}));
                mul_b = MUL_B_W'($signed({1'b0, x2_reg}));
            end
            ST_RB: begin
                mul_a = MUL_A_W'($signed({1'b0, xq_reg}));
                mul_b = MUL_B_W'($signed({1'b0, r_a_cur}));
            end
            ST_Y: begin
                mul_a = MUL_A_W'($signed({1'b0, depth_cap}));
                mul_b = MUL_B_W'(sine_cur);
            end
            ST_D: begin
                mul_a = MUL_A_W'($signed({1'b0, dw_cap}));
                mul_b = MUL_B_W'($signed({1'b0, WET_GAIN}));
            end
            ST_GW: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'($signed({1'b0, gdry}));
            end
            ST_DRY: begin
                mul_a = MUL_A_W'($signed(ram_rdata));
                mul_b = MUL_B_W'($signed({1'b0, w_a}));
            end
            ST_TA: begin
                mul_a = MUL_A_W'($signed(ram_rdata));
                mul_b = MUL_B_W'($signed({1'b0, df_reg}));
            end
            ST_TB: begin
                mul_a = MUL_A_W'(wet_sum);
                mul_b = MUL_B_W'($signed({1'b0, gwet_reg}));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = s_tdata[SAMPLE_BITS-1:0];
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_ptr_reg;
            ram_wdata = '0;
        end else if (s_accept) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = (state_reg == ST_GW) || (state_reg == ST_DRY);
    assign ram_raddr = (state_reg == ST_GW) ? ia_cur : ib_cur;

    lfoc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_WORDS)
    ) u_delay_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    lfoc_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .aclk        (aclk),
        .op_a        (mul_a),
        .op_b        (mul_b),
        .product_reg (mul_p)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            clr_ptr_reg    <= '0;
            wp_reg         <= '0;
            lfo_count_reg  <= '0;
            lfo_phase_reg  <= '0;
            base_delay_reg <= RST_BASE_DELAY;
            mod_depth_reg  <= RST_MOD_DEPTH;
            lfo_period_reg <= RST_LFO_PERIOD;
            phase_step_reg <= RST_PHASE_STEP;
            dry_wet_reg    <= RST_DRY_WET;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_DELAY: base_delay_reg <= cfg_wdata[BASE_W-1:0];
                    REG_MOD_DEPTH:  mod_depth_reg  <= cfg_wdata[DEPTH_W-1:0];
                    REG_LFO_PERIOD: lfo_period_reg <= cfg_wdata[PERIOD_W-1:0];
                    REG_PHASE_STEP: phase_step_reg <= cfg_wdata[STEP_W-1:0];
                    REG_DRY_WET:    dry_wet_reg    <= cfg_wdata[DRYWET_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_ptr_reg <= clr_ptr_reg + AW'(1);
                    if (clr_ptr_reg == AW'(DELAY_WORDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_X2;
                    end
                end
                ST_X2:  state_reg <= ST_RC;
                ST_RC:  state_reg <= ST_RB;
                ST_RB:  state_reg <= ST_Y;
                ST_Y:   state_reg <= ST_D;
                ST_D:   state_reg <= ST_GW;
                ST_GW:  state_reg <= ST_DRY;
                ST_DRY: state_reg <= ST_TA;
                ST_TA:  state_reg <= ST_TB;
                ST_TB:  state_reg <= ST_MIX;
                ST_MIX: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= TDATA_W'(y_sat);
                        wp_reg       <= (wp_reg == AW'(DELAY_WORDS - 1)) ? '0
                                        : wp_reg + AW'(1);
                        if (cnt_inc >= period_eff || cnt_inc == '0) begin
                            lfo_count_reg <= '0;
                            lfo_phase_reg <= '0;
                        end else begin
                            lfo_count_reg <= cnt_inc;
                            lfo_phase_reg <= lfo_phase_reg + phase_step_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg   <= $signed(s_tdata[SAMPLE_BITS-1:0]);
            xq_reg  <= x_cur;
            neg_reg <= t_cur[15];
        end
        case (state_reg)
            ST_X2: x2_reg <= p_hi15;
            ST_D: begin
                if ({18'b0, di_raw} >= DELAY_WORDS - 1) begin
                    di_reg <= AW'(DELAY_WORDS - 2);
                    df_reg <= 9'd256;
                end else begin
                    di_reg <= AW'(di_raw);
                    df_reg <= {1'b0, dq_cur[7:0]};
                end
            end
            ST_GW: begin
                gwet_reg <= mul_p[16 +: 16];
                ia_reg   <= ia_cur;
            end
            ST_DRY: acc_reg <= ACC_W'(mul_p) <<< 8;
            ST_TA:  wet_reg <= WET_W'(mul_p);
            ST_MIX: acc_reg <= acc_reg + ACC_W'(mul_p) + ROUND_HALF;
            default: begin
            end
        endcase
    end

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken while a word is in progress");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_write_at_wp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (ram_we && ram_waddr == wp_reg))
        else $error("accepted word not written at the write pointer");

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wp_reg} < (AW+1)'(DELAY_WORDS))
        else $error("write pointer out of range");

endmodule : lfo_modulated_chorus
`default_nettype wire
